// File: hw/rtl/brurs_pkg.sv
package brurs_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned NUM_CELLS = WORD_W;
    localparam int unsigned CNT_W     = $clog2(WORD_W);
    localparam int unsigned IDX_W     = 2;

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(WORD_W - 1);

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_LOWER = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_UPPER = IDX_W'(1);

    typedef enum logic [1:0] {
        LIM_IDLE,
        LIM_SPAN,
        LIM_DIV,
        LIM_DONE
    } lim_state_t;

    // one slot of the division chain
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] bits;
    } stage_t;

    // derived range settings handed to the datapath
    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] lower;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] limit;
    } lim_stat_t;

    // one restoring division step; a zero divisor degrades to a plain shift
    function automatic logic [WORD_W-1:0] div_step(
        input logic [WORD_W-1:0] rem,
        input logic              din,
        input logic [WORD_W-1:0] divisor
    );
        logic [WORD_W:0] shifted;
        shifted = {rem, din};
        if (shifted >= {1'b0, divisor})
        begin
            shifted = shifted - {1'b0, divisor};
        end
        return shifted[WORD_W-1:0];
    endfunction

endpackage

// File: hw/rtl/brurs_cell.sv
module brurs_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [brurs_pkg::WORD_W-1:0] divisor,
    input  brurs_pkg::stage_t            prev,
    output brurs_pkg::stage_t            curr
);
    import brurs_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] bits_reg;

    // control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev.valid;
        end
    end

    // remainder step, dividend bits move up one place
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= div_step(prev.rem, prev.bits[WORD_W-1], divisor);
            bits_reg <= {prev.bits[WORD_W-2:0], 1'b0};
        end
    end

    assign curr.valid = valid_reg;
    assign curr.rem   = rem_reg;
    assign curr.bits  = bits_reg;

endmodule

// File: hw/rtl/brurs_limit.sv
module brurs_limit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [brurs_pkg::IDX_W-1:0]  cfg_index,
    input  logic [brurs_pkg::WORD_W-1:0] cfg_data,
    output brurs_pkg::lim_stat_t         stat
);
    import brurs_pkg::*;

    lim_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] lower_reg, lower_next;
    logic [WORD_W-1:0] upper_reg, upper_next;
    logic [WORD_W-1:0] span_reg, span_next;
    logic [WORD_W-1:0] limit_reg, limit_next;
    logic [WORD_W-1:0] rem_reg, rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LIM_IDLE;
            cnt_reg   <= '0;
            lower_reg <= '0;
            upper_reg <= ALL_ONES;
            span_reg  <= '0;
            limit_reg <= ALL_ONES;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            span_reg  <= span_next;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        span_next  = span_reg;
        limit_next = limit_reg;
        rem_next   = rem_reg;

        case (state_reg)
            LIM_SPAN:
            begin
                span_next  = upper_reg - lower_reg + WORD_W'(1);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = LIM_DIV;
            end
            LIM_DIV:
            begin
                // all-ones mod span, one dividend bit per cycle
                rem_next = div_step(rem_reg, 1'b1, span_reg);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = LIM_DONE;
                end
            end
            LIM_DONE:
            begin
                limit_next = (span_reg == '0) ? ALL_ONES : (ALL_ONES - rem_reg);
                state_next = LIM_IDLE;
            end
            default:
            begin
                state_next = LIM_IDLE;
            end
        endcase

        // a bound write restarts the derivation
        if (cfg_we && (cfg_index == REG_LOWER))
        begin
            lower_next = cfg_data;
            state_next = LIM_SPAN;
        end
        else if (cfg_we && (cfg_index == REG_UPPER))
        begin
            upper_next = cfg_data;
            state_next = LIM_SPAN;
        end
    end

    assign stat.busy  = (state_reg != LIM_IDLE);
    assign stat.lower = lower_reg;
    assign stat.span  = span_reg;
    assign stat.limit = limit_reg;

endmodule

// File: hw/rtl/bounded_uniform_rejection_sampler.sv
// bounded uniform rejection sampler
//
// input channel: entropy_word with in_valid / in_stall; one raw 64-bit word per
// transaction. output channel: sample_value with out_valid / out_stall; zero or
// one sample per input word, in input order.
// configuration: cfg_we, cfg_index (0 lower bound, 1 upper bound), cfg_data;
// writes to other indexes are dropped. write only while the block is empty.
// after a bound write the range and acceptance limit are rederived: in_stall
// stays high while a one-bit-per-cycle divider computes all-ones mod span.
// throughput: one word per cycle while in_stall is low. an input word passes
// through 64 division cells and then the output register before out_valid; each
// cell retires one dividend bit of word mod span.
// rejected words (word at or above the limit, span above one) never enter the chain.
// reset: bounds go to the full 64-bit range, the chain and output empty.
// stalls: a waiting result sits in the output register; the chain keeps moving
// while its last cell is empty or the output register can take its result, otherwise it freezes and in_stall rises.
module bounded_uniform_rejection_sampler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [brurs_pkg::IDX_W-1:0]  cfg_index,
    input  logic [brurs_pkg::WORD_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [brurs_pkg::WORD_W-1:0] entropy_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [brurs_pkg::WORD_W-1:0] sample_value
);
    import brurs_pkg::*;

    lim_stat_t         stat;
    stage_t            chain [0:NUM_CELLS];
    logic              chain_en;
    logic              reject;
    logic              out_take;
    logic              out_valid_reg;
    logic [WORD_W-1:0] sample_reg;

    // bounds, span and acceptance limit
    brurs_limit u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat)
    );

    // the output register frees up when empty or being taken
    assign out_take = !out_valid_reg || !out_stall;

    // chain advances unless a finished result would be lost
    assign chain_en = out_take || !chain[NUM_CELLS].valid;
    assign in_stall = stat.busy || !chain_en;

    // spans of zero and one never reject
    assign reject = (stat.span > WORD_W'(1)) && (entropy_word >= stat.limit);

    assign chain[0].valid = in_valid && !in_stall && !reject;
    assign chain[0].rem   = '0;
    assign chain[0].bits  = entropy_word;

    // one cell per dividend bit, most significant first
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        brurs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (chain_en),
            .divisor (stat.span),
            .prev    (chain[i]),
            .curr    (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= chain[NUM_CELLS].valid;
        end
    end

    // zero span leaves the word itself as remainder, so this covers the wrap case
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            sample_reg <= chain[NUM_CELLS].rem + stat.lower;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_reg;

endmodule
